// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the radix emitter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/sirde_pkg.sv =====
// ----------------------------------------------------------------------------
// sirde_pkg
// Types and constants shared by the radix digit emitter modules.
// ----------------------------------------------------------------------------
package sirde_pkg;

  // Width of the radix register and of the divisor path.
  localparam int unsigned RADIX_W = 5;
  // Width of one digit value; the alphabet holds sixteen symbols.
  localparam int unsigned DIGIT_W = 4;
  // Quotient bits resolved by the divider in each cycle.
  localparam int unsigned DIV_BITS_PER_STEP = 8;

  localparam logic [7:0] MINUS_SYM = 8'h2D;
  localparam logic [7:0] PLUS_SYM  = 8'h2B;

  localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
  localparam logic [63:0]        ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [63:0]        ALPHA_HI_RESET = 64'h0000_0000_0000_3938;

  // Register index, taken from the 8-byte aligned APB address.
  typedef enum logic [1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } sirde_reg_e;

endpackage

// ===== design/signed_int_radix_digit_emitter_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_radix_digit_emitter_top
// Converts signed integers to text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// Each beat on the input channel carries one signed value; the block answers
// with its text as a run of output beats, one symbol each: a minus symbol for
// a negative value, then the digits most significant first, mapped through the
// alphabet registers, with last set on the final symbol. The most negative
// value prints as its true magnitude. If the radix lies outside two to
// MAX_RADIX, or one of the alphabet symbols in use is zero, plus, minus or a
// repeat, the value is consumed and no beat appears. The block handles one
// value at a time and stalls its input while it works. The digits are found
// by one shared divider that resolves eight quotient bits per cycle; the
// digits are kept in a small RAM and replayed most significant first, each
// symbol read from the RAM and then handed to the output register, which the
// receiver may stall. The next value is taken while the final symbol still
// waits in the output register. The registers sit at byte addresses 0, 8 and
// 16 of the APB port (radix, low alphabet bytes, high alphabet bytes) and
// should be written only while no conversion is under way.
module signed_int_radix_digit_emitter_top
  import sirde_pkg::*;
#(
  parameter int unsigned MAX_RADIX   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  // Input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  // Output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             symbol_o,
  output logic                   last_o
);

`include "assert_macros.svh"

  // The magnitude carries one extra bit so that the most negative value fits.
  localparam int unsigned MAG_W = VALUE_WIDTH + 1;
  localparam int unsigned AW    = $clog2(MAG_W);
  localparam int unsigned NW    = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MINUS,
    ST_READ,
    ST_SEND
  } state_e;

  // Configuration registers.
  logic [RADIX_W-1:0] radix_q;
  logic [63:0]        alpha_lo_q;
  logic [63:0]        alpha_hi_q;
  logic [127:0]       alpha;

  // Sequencer state and payload.
  state_e           state_q;
  logic             neg_q;
  logic [MAG_W-1:0] mag_q;
  logic [NW-1:0]    nd_q;
  logic [AW-1:0]    ptr_q;
  logic             out_valid_q;
  logic [7:0]       symbol_q;
  logic             last_q;

  // Divider and digit store connections.
  logic               div_start;
  logic [MAG_W-1:0]   div_dividend;
  logic               div_done;
  logic [MAG_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;

  logic             cfg_write;
  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             setup_ok;
  logic [MAG_W-1:0] value_ext;

  function automatic logic [7:0] sym_of(input logic [127:0] a, input logic [DIGIT_W-1:0] d);
    sym_of = a[{d, 3'b000} +: 8];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads return the
  // addressed register and unused addresses read as zero.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      alpha_lo_q <= ALPHA_LO_RESET;
      alpha_hi_q <= ALPHA_HI_RESET;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_RADIX:    radix_q    <= pwdata[RADIX_W-1:0];
        REG_ALPHA_LO: alpha_lo_q <= pwdata;
        REG_ALPHA_HI: alpha_hi_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_RADIX:    prdata = 64'(radix_q);
      REG_ALPHA_LO: prdata = alpha_lo_q;
      REG_ALPHA_HI: prdata = alpha_hi_q;
      default:      prdata = '0;
    endcase
  end

  assign alpha = {alpha_hi_q, alpha_lo_q};

  // --------------------------------------------------------------------------
  // Setup check. Every symbol below the radix is compared with the reserved
  // bytes and with each earlier symbol; the comparisons are independent and
  // are reduced to one flag that the sequencer samples before dividing.
  // --------------------------------------------------------------------------
  always_comb begin
    logic       bad;
    logic [7:0] s;
    bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      s = sym_of(alpha, DIGIT_W'(i));
      if (radix_q > RADIX_W'(i)) begin
        if (s == 8'h00 || s == MINUS_SYM || s == PLUS_SYM) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (sym_of(alpha, DIGIT_W'(j)) == s) begin
            bad = 1'b1;
          end
        end
      end
    end
    setup_ok = !bad;
  end

  // --------------------------------------------------------------------------
  // Handshakes. The output register is free when empty or being taken, and
  // it is loaded whenever the sequencer hands it a new symbol.
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && ((state_q == ST_MINUS) || (state_q == ST_SEND));

  // Sign-extend and negate in the wider width; the most negative input then
  // yields its true magnitude.
  assign value_ext = {value_i[VALUE_WIDTH-1], value_i};

  // Digits come out least significant first and are stored at rising indices;
  // the replay walks the store downwards.
  assign div_start    = ((state_q == ST_CHECK) && setup_ok) ||
                        ((state_q == ST_DIV) && div_done && (div_quot != '0));
  assign div_dividend = (state_q == ST_CHECK) ? mag_q : div_quot;
  assign ram_we       = (state_q == ST_DIV) && div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      nd_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      symbol_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            neg_q   <= value_i[VALUE_WIDTH-1];
            mag_q   <= value_i[VALUE_WIDTH-1] ? (~value_ext + 1'b1) : value_ext;
            nd_q    <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= setup_ok ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) begin
            nd_q <= nd_q + 1'b1;
            if (div_quot == '0) begin
              ptr_q   <= nd_q[AW-1:0];
              state_q <= neg_q ? ST_MINUS : ST_READ;
            end
          end
        end
        ST_MINUS: begin
          if (out_free) begin
            symbol_q    <= MINUS_SYM;
            last_q      <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          // The digit store's read port is registered, so the addressed digit is presented in the following cycle.
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (out_free) begin
            symbol_q    <= sym_of(alpha, ram_rdata);
            last_q      <= (ptr_q == '0);
            if (ptr_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              ptr_q   <= ptr_q - 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

  // --------------------------------------------------------------------------
  // Shared divider and digit store.
  // --------------------------------------------------------------------------
  sirde_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  sirde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAG_W)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nd_q[AW-1:0]),
    .wdata_i (div_rem),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  `ASSERT_IMPLIES(a_done_only_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `ASSERT_IMPLIES(a_minus_only_negative, clk_i, rst_ni, state_q == ST_MINUS, neg_q)
  `ASSERT_IMPLIES(a_digit_index_in_range, clk_i, rst_ni, ram_we, nd_q < NW'(MAG_W))
  `ASSERT_NEXT(a_final_symbol_ends_text, clk_i, rst_ni,
               (state_q == ST_SEND) && out_free && (ptr_q == '0),
               (state_q == ST_IDLE) && out_valid_q && last_q)

endmodule

// ===== design/sirde_ram.sv =====
// ----------------------------------------------------------------------------
// sirde_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sirde_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sirde_div.sv =====
// ----------------------------------------------------------------------------
// sirde_div
// Iterative restoring divider of a wide magnitude by a small radix.
// ----------------------------------------------------------------------------
module sirde_div
  import sirde_pkg::*;
#(
  parameter int unsigned MAG_W = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MAG_W-1:0]   dividend_i,
  input  logic [RADIX_W-1:0] divisor_i,
  output logic               done_o,
  output logic [MAG_W-1:0]   quotient_o,
  output logic [DIGIT_W-1:0] remainder_o
);

`include "assert_macros.svh"

  localparam int unsigned STEPS = (MAG_W + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
  localparam int unsigned PAD_W = STEPS * DIV_BITS_PER_STEP;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [PAD_W-1:0]   shreg_q, shreg_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  // Each cycle shifts a group of dividend bits into the partial remainder.
  // The remainder stays below the divisor, so it fits in one bit fewer.
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [PAD_W-1:0]   sh;
    logic               qbit;
    r  = rem_q;
    sh = shreg_q;
    for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
      r    = {r[RADIX_W-2:0], sh[PAD_W-1]};
      qbit = (r >= divisor_i);
      if (qbit) begin
        r = r - divisor_i;
      end
      sh = {sh[PAD_W-2:0], qbit};
    end
    rem_d   = r;
    shreg_d = sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      shreg_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        rem_q   <= '0;
        shreg_q <= PAD_W'(dividend_i);
      end else if (busy_q) begin
        rem_q   <= rem_d;
        shreg_q <= shreg_d;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = shreg_q[MAG_W-1:0];
  assign remainder_o = rem_q[DIGIT_W-1:0];

  `ASSERT_IMPLIES(a_no_start_when_busy, clk_i, rst_ni, start_i, !busy_q)
  `ASSERT_NEXT(a_busy_ends_in_done, clk_i, rst_ni, busy_q && !start_i, busy_q || done_q)
  `ASSERT_IMPLIES(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)

endmodule
